### design/rcwt_pkg.sv
// ----------------------------------------------------------------------------
// rcwt_pkg
// Shared widths, codes and pipeline types of the raycast wall column texel unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rcwt_pkg;

  // screen geometry defaults
  localparam int SCREEN_WIDTH_DEF  = 1024;
  localparam int SCREEN_HEIGHT_DEF = 768;

  // field widths
  localparam int COL_W   = 10;
  localparam int ROW_W   = 10;
  localparam int HQ8_W   = 24;
  localparam int FRAC_W  = 16;
  localparam int ANG_W   = 16;
  localparam int PIX_W   = 20;
  localparam int REG_W   = 2;
  localparam int TSEL_W  = 2;
  localparam int TEXEL_W = 20;
  localparam int COLOR_W = 24;
  localparam int TEX_W   = 11;
  localparam int CFG_A_W = 2;

  // internal datapath widths
  localparam int Q9_SHIFT = 9;                  // 1/512 pixel units
  localparam int S_W      = HQ8_W + 1;          // texture row offset in 1/512 pixel
  localparam int YC_W     = S_W - Q9_SHIFT;     // row coordinates after the shift
  localparam int NUM_W    = TEX_W + S_W;        // dividend tex_height * s
  localparam int DEN_W    = HQ8_W + 1;          // divisor 2 * wall height
  localparam int Q_W      = TEX_W;              // quotient bits kept before saturation
  localparam int TXP_W    = TEX_W + FRAC_W;     // tex_width * hit_frac
  localparam int TYP_W    = 2 * TEX_W;          // ty * tex_width

  // cycles from the accepting edge to the edge that takes the result
  localparam int PIPE_LAT = Q_W + 6;

  // angle thresholds, one full turn is 2^16
  localparam logic [ANG_W-1:0] ANG_QUARTER = ANG_W'(16384);
  localparam logic [ANG_W-1:0] ANG_HALF    = ANG_W'(32768);
  localparam logic [ANG_W-1:0] ANG_3QUART  = ANG_W'(49152);

  typedef enum logic [REG_W-1:0] {
    REGION_CEILING = 2'd0,
    REGION_WALL    = 2'd1,
    REGION_FLOOR   = 2'd2
  } region_t;

  typedef enum logic [TSEL_W-1:0] {
    TEX_NORTH = 2'd0,
    TEX_SOUTH = 2'd1,
    TEX_WEST  = 2'd2,
    TEX_EAST  = 2'd3
  } tex_sel_t;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_CEILING_COLOR = 2'd0,
    CFG_FLOOR_COLOR   = 2'd1,
    CFG_TEX_WIDTH     = 2'd2,
    CFG_TEX_HEIGHT    = 2'd3
  } cfg_reg_t;

  localparam logic [TEX_W-1:0] TEX_SIZE_RST = TEX_W'(64);

  // per-word control that rides alongside the divider
  typedef struct packed {
    logic             vld;
    logic [PIX_W-1:0] pix;
    region_t          region;
    tex_sel_t         tsel;
    logic [TEX_W-1:0] tx;
  } side_t;

endpackage

`default_nettype wire

### design/rcwt_front.sv
// ----------------------------------------------------------------------------
// rcwt_front
// Row classification, texture choice and the two multiplies feeding the divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcwt_front import rcwt_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_fire,
  input  wire logic [COL_W-1:0]   in_column,
  input  wire logic [ROW_W-1:0]   in_row,
  input  wire logic [HQ8_W-1:0]   in_wall_height_q8,
  input  wire logic [FRAC_W-1:0]  in_hit_frac,
  input  wire logic               in_horizontal_hit,
  input  wire logic [ANG_W-1:0]   in_view_angle,
  input  wire logic [TEX_W-1:0]   tex_width,
  input  wire logic [TEX_W-1:0]   tex_height,
  output side_t                   side_o,
  output logic [NUM_W-1:0]        num_o,
  output logic [DEN_W-1:0]        den_o
);

  localparam int HALF_Q9 = (SCREEN_HEIGHT / 2) * (1 << Q9_SHIFT);
  localparam logic [S_W-1:0]   HALF_Q9_V = S_W'(HALF_Q9);
  localparam logic [HQ8_W-1:0] HSCR_Q8_V = HQ8_W'(SCREEN_HEIGHT * 256);
  localparam logic [YC_W-1:0]  SCR_H_V   = YC_W'(SCREEN_HEIGHT);

  logic [S_W-1:0]   hq8_x;
  logic [S_W-1:0]   above_diff;
  logic [S_W-1:0]   end_sum;
  logic [YC_W-1:0]  row_x;
  logic [YC_W-1:0]  y_off;
  logic [YC_W-1:0]  y_end;
  logic             is_ceil;
  logic             is_wall;
  logic [ROW_W-1:0] y_tex;
  logic [HQ8_W-1:0] excess;
  logic [31:0]      pix_w;
  tex_sel_t         pick;

  logic [PIX_W-1:0]  pix_nxt;
  region_t           region_nxt;
  tex_sel_t          tsel_nxt;
  logic [S_W-1:0]    s_nxt;

  logic              s1_vld_r;
  logic [PIX_W-1:0]  s1_pix_r;
  region_t           s1_region_r;
  tex_sel_t          s1_tsel_r;
  logic [S_W-1:0]    s1_s_r;
  logic [DEN_W-1:0]  s1_den_r;
  logic [FRAC_W-1:0] s1_frac_r;

  logic [TXP_W-1:0]  tx_prod;
  logic [NUM_W-1:0]  num_nxt;
  side_t             side_nxt;
  side_t             side_r;
  logic [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]  den_r;

  // wall spans trunc(half - h/2) up to, not including, floor(half + h/2 - 1), in 1/512 pixel
  assign hq8_x      = S_W'(in_wall_height_q8);
  assign above_diff = HALF_Q9_V - hq8_x;
  assign end_sum    = HALF_Q9_V + hq8_x - (S_W'(1) << Q9_SHIFT);
  assign row_x      = YC_W'(in_row);
  assign y_off      = (hq8_x < HALF_Q9_V) ? above_diff[S_W-1:Q9_SHIFT] : '0;
  assign y_end      = end_sum[S_W-1:Q9_SHIFT];

  assign is_ceil = row_x < y_off;
  assign is_wall = !is_ceil && (row_x < y_end) && (row_x < SCR_H_V) &&
                   (in_wall_height_q8 != '0);

  // texture row counter starts at the first visible wall row
  assign y_tex  = ROW_W'(row_x - y_off);
  assign excess = (in_wall_height_q8 > HSCR_Q8_V) ? in_wall_height_q8 - HSCR_Q8_V : '0;
  assign s_nxt  = S_W'({y_tex, {Q9_SHIFT{1'b0}}}) + S_W'(excess);

  assign pix_w   = 32'(in_row) * 32'(SCREEN_WIDTH) + 32'(in_column);
  assign pix_nxt = pix_w[PIX_W-1:0];

  always_comb begin
    if (in_horizontal_hit) begin
      pick = (in_view_angle <= ANG_HALF) ? TEX_NORTH : TEX_SOUTH;
    end else begin
      pick = (in_view_angle >= ANG_QUARTER && in_view_angle <= ANG_3QUART) ?
             TEX_WEST : TEX_EAST;
    end
  end

  always_comb begin
    if (is_ceil) begin
      region_nxt = REGION_CEILING;
      tsel_nxt   = TEX_NORTH;
    end else if (is_wall) begin
      region_nxt = REGION_WALL;
      tsel_nxt   = pick;
    end else begin
      region_nxt = REGION_FLOOR;
      tsel_nxt   = TEX_NORTH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_fire;
    end
    s1_pix_r    <= pix_nxt;
    s1_region_r <= region_nxt;
    s1_tsel_r   <= tsel_nxt;
    s1_s_r      <= s_nxt;
    s1_den_r    <= {in_wall_height_q8, 1'b0};
    s1_frac_r   <= in_hit_frac;
  end

  // second stage: texel column and the dividend
  assign tx_prod = TXP_W'(tex_width) * TXP_W'(s1_frac_r);
  assign num_nxt = NUM_W'(tex_height) * NUM_W'(s1_s_r);

  always_comb begin
    side_nxt.vld    = s1_vld_r;
    side_nxt.pix    = s1_pix_r;
    side_nxt.region = s1_region_r;
    side_nxt.tsel   = s1_tsel_r;
    side_nxt.tx     = tx_prod[TXP_W-1:FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.vld <= 1'b0;
    end else begin
      side_r <= side_nxt;
    end
    num_r <= num_nxt;
    den_r <= s1_den_r;
  end

  assign side_o = side_r;
  assign num_o  = num_r;
  assign den_o  = den_r;

endmodule

`default_nettype wire

### design/rcwt_divider.sv
// ----------------------------------------------------------------------------
// rcwt_divider
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcwt_divider import rcwt_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire side_t            side_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output side_t                 side_o,
  output logic [Q_W-1:0]        q_o,
  output logic                  ovf_o
);

  side_t            side_r [Q_W+1];
  logic [NUM_W-1:0] rem_r  [Q_W];
  logic [DEN_W-1:0] den_r  [Q_W];
  logic [Q_W-1:0]   q_r    [Q_W+1];
  logic             ovf_r  [Q_W+1];
  logic [NUM_W-1:0] den_top;

  // quotient does not fit Q_W bits: the row saturates later anyway
  assign den_top = {den_i, {Q_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r[0].vld <= 1'b0;
    end else begin
      side_r[0] <= side_i;
    end
    rem_r[0] <= num_i;
    den_r[0] <= den_i;
    q_r[0]   <= '0;
    ovf_r[0] <= num_i >= den_top;
  end

  for (genvar j = 1; j <= Q_W; j++) begin : g_step
    localparam int SH = Q_W - j;
    logic [NUM_W-1:0] dsh;
    logic             ge;

    assign dsh = NUM_W'(den_r[j-1]) << SH;
    assign ge  = rem_r[j-1] >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[j].vld <= 1'b0;
      end else begin
        side_r[j] <= side_r[j-1];
      end
      q_r[j]   <= {q_r[j-1][Q_W-2:0], ge};
      ovf_r[j] <= ovf_r[j-1];
    end

    if (j < Q_W) begin : g_fwd
      always_ff @(posedge clk) begin
        rem_r[j] <= ge ? rem_r[j-1] - dsh : rem_r[j-1];
        den_r[j] <= den_r[j-1];
      end
    end
  end

  assign side_o = side_r[Q_W];
  assign q_o    = q_r[Q_W];
  assign ovf_o  = ovf_r[Q_W];

endmodule

`default_nettype wire

### design/rcwt_texel.sv
// ----------------------------------------------------------------------------
// rcwt_texel
// Texture row saturation, texel index and the registered result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcwt_texel import rcwt_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire side_t               side_i,
  input  wire logic [Q_W-1:0]      q_i,
  input  wire logic                ovf_i,
  input  wire logic [TEX_W-1:0]    tex_width,
  input  wire logic [TEX_W-1:0]    tex_height,
  input  wire logic [COLOR_W-1:0]  ceiling_color,
  input  wire logic [COLOR_W-1:0]  floor_color,
  output logic                     out_valid,
  output logic [PIX_W-1:0]         out_pixel_index,
  output logic [REG_W-1:0]         out_region,
  output logic [TSEL_W-1:0]        out_texture_select,
  output logic [TEXEL_W-1:0]       out_texel_index,
  output logic [COLOR_W-1:0]       out_fill_color
);

  logic [TEX_W-1:0]   ty_nxt;
  side_t              t1_side_r;
  logic [TEX_W-1:0]   t1_ty_r;
  side_t              t2_side_r;
  logic [TYP_W-1:0]   t2_prod_r;
  logic [TYP_W:0]     texel_sum;

  logic               out_valid_r;
  logic [PIX_W-1:0]   out_pix_r;
  region_t            out_region_r;
  tex_sel_t           out_tsel_r;
  logic [TEXEL_W-1:0] out_texel_r;
  logic [COLOR_W-1:0] out_fill_r;
  logic [TEXEL_W-1:0] texel_nxt;
  logic [COLOR_W-1:0] fill_nxt;

  always_comb begin
    if (tex_height == '0) begin
      ty_nxt = '0;
    end else if (ovf_i || q_i >= tex_height) begin
      ty_nxt = tex_height - TEX_W'(1);
    end else begin
      ty_nxt = q_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_side_r.vld <= 1'b0;
      t2_side_r.vld <= 1'b0;
    end else begin
      t1_side_r <= side_i;
      t2_side_r <= t1_side_r;
    end
    t1_ty_r   <= ty_nxt;
    t2_prod_r <= TYP_W'(t1_ty_r) * TYP_W'(tex_width);
  end

  assign texel_sum = (TYP_W+1)'(t2_prod_r) + (TYP_W+1)'(t2_side_r.tx);

  always_comb begin
    case (t2_side_r.region)
      REGION_CEILING: begin
        texel_nxt = '0;
        fill_nxt  = ceiling_color;
      end
      REGION_WALL: begin
        texel_nxt = texel_sum[TEXEL_W-1:0];
        fill_nxt  = '0;
      end
      default: begin
        texel_nxt = '0;
        fill_nxt  = floor_color;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= t2_side_r.vld;
    end
    out_pix_r    <= t2_side_r.pix;
    out_region_r <= t2_side_r.region;
    out_tsel_r   <= t2_side_r.tsel;
    out_texel_r  <= texel_nxt;
    out_fill_r   <= fill_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_pixel_index    = out_pix_r;
  assign out_region         = out_region_r;
  assign out_texture_select = out_tsel_r;
  assign out_texel_index    = out_texel_r;
  assign out_fill_color     = out_fill_r;

endmodule

`default_nettype wire

### design/raycast_wall_column_texel.sv
// ----------------------------------------------------------------------------
// raycast_wall_column_texel
// Path: a taken start reaches out_valid through the front registers, the divider input
// register, the 11-stage quotient pipeline (one bit per stage) and the texel registers.
// Throughput: one pixel word per clock, busy stays low outside reset.
// Reset: synchronous on rst_n, clears all valid bits and sets the texture size
// registers to 64 and both colors to 0; busy and cfg_ready follow reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module raycast_wall_column_texel import rcwt_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [COL_W-1:0]    in_column,
  input  wire logic [ROW_W-1:0]    in_row,
  input  wire logic [HQ8_W-1:0]    in_wall_height_q8,
  input  wire logic [FRAC_W-1:0]   in_hit_frac,
  input  wire logic                in_horizontal_hit,
  input  wire logic [ANG_W-1:0]    in_view_angle,
  output logic                     out_valid,
  output logic [PIX_W-1:0]         out_pixel_index,
  output logic [REG_W-1:0]         out_region,
  output logic [TSEL_W-1:0]        out_texture_select,
  output logic [TEXEL_W-1:0]       out_texel_index,
  output logic [COLOR_W-1:0]       out_fill_color,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CFG_A_W-1:0]  cfg_index,
  input  wire logic [COLOR_W-1:0]  cfg_data
);

  logic               in_fire;
  logic               cfg_fire;
  logic [COLOR_W-1:0] ceiling_color_r;
  logic [COLOR_W-1:0] floor_color_r;
  logic [TEX_W-1:0]   tex_width_r;
  logic [TEX_W-1:0]   tex_height_r;

  side_t              fr_side;
  logic [NUM_W-1:0]   fr_num;
  logic [DEN_W-1:0]   fr_den;
  side_t              dv_side;
  logic [Q_W-1:0]     dv_q;
  logic               dv_ovf;

  assign busy      = ~rst_n;
  assign cfg_ready = rst_n;
  assign in_fire   = start & ~busy;
  assign cfg_fire  = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceiling_color_r <= '0;
      floor_color_r   <= '0;
      tex_width_r     <= TEX_SIZE_RST;
      tex_height_r    <= TEX_SIZE_RST;
    end else if (cfg_fire) begin
      case (cfg_reg_t'(cfg_index))
        CFG_CEILING_COLOR: ceiling_color_r <= cfg_data;
        CFG_FLOOR_COLOR:   floor_color_r   <= cfg_data;
        CFG_TEX_WIDTH:     tex_width_r     <= cfg_data[TEX_W-1:0];
        CFG_TEX_HEIGHT:    tex_height_r    <= cfg_data[TEX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rcwt_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_fire           (in_fire),
    .in_column         (in_column),
    .in_row            (in_row),
    .in_wall_height_q8 (in_wall_height_q8),
    .in_hit_frac       (in_hit_frac),
    .in_horizontal_hit (in_horizontal_hit),
    .in_view_angle     (in_view_angle),
    .tex_width         (tex_width_r),
    .tex_height        (tex_height_r),
    .side_o            (fr_side),
    .num_o             (fr_num),
    .den_o             (fr_den)
  );

  rcwt_divider u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .side_i (fr_side),
    .num_i  (fr_num),
    .den_i  (fr_den),
    .side_o (dv_side),
    .q_o    (dv_q),
    .ovf_o  (dv_ovf)
  );

  rcwt_texel u_texel (
    .clk                (clk),
    .rst_n              (rst_n),
    .side_i             (dv_side),
    .q_i                (dv_q),
    .ovf_i              (dv_ovf),
    .tex_width          (tex_width_r),
    .tex_height         (tex_height_r),
    .ceiling_color      (ceiling_color_r),
    .floor_color        (floor_color_r),
    .out_valid          (out_valid),
    .out_pixel_index    (out_pixel_index),
    .out_region         (out_region),
    .out_texture_select (out_texture_select),
    .out_texel_index    (out_texel_index),
    .out_fill_color     (out_fill_color)
  );

endmodule

`default_nettype wire

### design/rcwt_checker.sv
// ----------------------------------------------------------------------------
// rcwt_checker
// Port-level checks of the texel unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcwt_checker import rcwt_pkg::*; #(
  parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic [COL_W-1:0]   in_column,
  input wire logic [ROW_W-1:0]   in_row,
  input wire logic               out_valid,
  input wire logic [PIX_W-1:0]   out_pixel_index,
  input wire logic [REG_W-1:0]   out_region,
  input wire logic [TSEL_W-1:0]  out_texture_select,
  input wire logic [TEXEL_W-1:0] out_texel_index,
  input wire logic [COLOR_W-1:0] out_fill_color
);

  logic        in_fire;
  logic [31:0] pix_w;
  logic [PIX_W-1:0] pix_exp;

  assign in_fire = start && !busy;
  assign pix_w   = 32'(in_row) * 32'(SCREEN_WIDTH) + 32'(in_column);
  assign pix_exp = pix_w[PIX_W-1:0];

  // every result word comes from a pixel taken a fixed latency earlier
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_fire, PIPE_LAT))
    else $error("result word without a matching start");

  // pixel index travels with its word through the whole pipeline
  a_pix_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pixel_index == $past(pix_exp, PIPE_LAT))
    else $error("pixel index does not match the accepted row and column");

  a_nonwall_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_region != REGION_WALL) |->
      (out_texel_index == '0 && out_texture_select == TEX_NORTH))
    else $error("texture fields set on a ceiling or floor pixel");

  a_wall_nofill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_region == REGION_WALL) |-> out_fill_color == '0)
    else $error("fill color set on a wall pixel");

endmodule

bind raycast_wall_column_texel rcwt_checker #(
  .SCREEN_WIDTH (SCREEN_WIDTH)
) u_rcwt_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .in_column          (in_column),
  .in_row             (in_row),
  .out_valid          (out_valid),
  .out_pixel_index    (out_pixel_index),
  .out_region         (out_region),
  .out_texture_select (out_texture_select),
  .out_texel_index    (out_texel_index),
  .out_fill_color     (out_fill_color)
);

`default_nettype wire
